>>> sv/spg_pkg.sv
// Shared types and constants for the stepper pulse train generator.
// No dependencies; imported by spg_core and stepper_pulse_train_generator.
`default_nettype none

package spg_pkg;

	// Command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_MOVE  = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_ABORT = 3'd3;
	localparam logic [2:0] CMD_SETP  = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY       = 2'd2;

	// Reset values
	localparam logic [15:0] MIN_PERIOD_RST = 16'd199;
	localparam logic [15:0] MAX_PERIOD_RST = 16'd1199;
	localparam logic [16:0] DUTY_RST       = 17'd32768;
	localparam logic [15:0] RELOAD_RST     = 16'd1199;
	localparam logic [16:0] COMPARE_RST    = 17'd600;

	// Q16 value of 1.0
	localparam logic [16:0] DUTY_ONE = 17'd65536;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] pulse_target;
		logic        direction;
		logic [15:0] period_reload;
	} item_t;

	typedef struct packed {
		logic        step_level;
		logic        direction_level;
		logic        enable_level;
		logic        busy_res;
		logic        move_done;
		logic        aborted;
		logic        status;
		logic [31:0] pulses_done;
	} result_t;

	typedef struct packed {
		logic [15:0] min_period;
		logic [15:0] max_period;
		logic [16:0] duty_fraction;
	} cfg_t;

endpackage

`default_nettype wire

>>> sv/spg_core.sv
// Move state registers and the single-pass update for one command.
// Depends on spg_pkg.
`default_nettype none

module spg_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire spg_pkg::item_t  item,
	input  wire spg_pkg::cfg_t   cfg,
	output spg_pkg::result_t     res
);
	import spg_pkg::*;

	logic [15:0] tick_count_q, tick_count_n;
	logic [15:0] reload_q, reload_n;
	logic [16:0] compare_q, compare_n;
	logic [31:0] pulse_count_q, pulse_count_n;
	logic [31:0] pulse_goal_q, pulse_goal_n;
	logic        running_q, running_n;
	logic        dir_q, dir_n;
	logic        enable_q, enable_n;
	logic        abort_q, abort_n;
	logic        done, rejected;

	logic [16:0] period_op;
	logic [33:0] prod;
	logic [16:0] compare_calc;
	logic        duty_ok;
	logic        in_window;
	logic [31:0] pulse_inc;

	// compare = floor(duty * (reload + 1) / 65536); setp uses the new reload
	assign period_op = (item.cmd == CMD_SETP) ? ({1'b0, item.period_reload} + 17'd1)
	                                          : ({1'b0, reload_q} + 17'd1);
	assign prod         = 34'(cfg.duty_fraction) * 34'(period_op);
	assign compare_calc = prod[32:16];
	assign duty_ok      = (cfg.duty_fraction <= DUTY_ONE);
	assign in_window    = (item.period_reload >= cfg.min_period) &&
	                      (item.period_reload <= cfg.max_period);
	// saturating pulse increment
	assign pulse_inc    = (pulse_count_q == '1) ? pulse_count_q : pulse_count_q + 32'd1;

	// Next state for the current command
	always_comb begin
		tick_count_n  = tick_count_q;
		reload_n      = reload_q;
		compare_n     = compare_q;
		pulse_count_n = pulse_count_q;
		pulse_goal_n  = pulse_goal_q;
		running_n     = running_q;
		dir_n         = dir_q;
		enable_n      = enable_q;
		abort_n       = abort_q;
		done          = 1'b0;
		rejected      = 1'b0;
		case (item.cmd)
			CMD_TICK: begin
				if (running_q) begin
					if (tick_count_q >= reload_q) begin
						tick_count_n = '0;
						if (pulse_inc >= pulse_goal_q) begin
							running_n     = 1'b0;
							pulse_count_n = '0;
							pulse_goal_n  = '0;
							done          = 1'b1;
						end else begin
							pulse_count_n = pulse_inc;
						end
					end else begin
						tick_count_n = tick_count_q + 16'd1;
					end
				end
			end
			CMD_MOVE: begin
				abort_n       = 1'b0;
				pulse_count_n = '0;
				pulse_goal_n  = item.pulse_target;
				dir_n         = item.direction;
				enable_n      = 1'b1;
				tick_count_n  = '0;
				running_n     = 1'b1;
				if (duty_ok) begin
					compare_n = compare_calc;
				end
			end
			CMD_STOP: begin
				running_n     = 1'b0;
				pulse_count_n = '0;
				pulse_goal_n  = '0;
			end
			CMD_ABORT: begin
				abort_n       = 1'b1;
				running_n     = 1'b0;
				pulse_count_n = '0;
				pulse_goal_n  = '0;
			end
			CMD_SETP: begin
				if (in_window) begin
					reload_n = item.period_reload;
					if (duty_ok) begin
						compare_n = compare_calc;
					end
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result seen after this command
	always_comb begin
		res.step_level      = running_n && ({1'b0, tick_count_n} < compare_n);
		res.direction_level = dir_n;
		res.enable_level    = enable_n;
		res.busy_res        = running_n;
		res.move_done       = done;
		res.aborted         = abort_n;
		res.status          = rejected;
		res.pulses_done     = pulse_count_n;
	end

	// State registers, updated once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q  <= '0;
			reload_q      <= RELOAD_RST;
			compare_q     <= COMPARE_RST;
			pulse_count_q <= '0;
			pulse_goal_q  <= '0;
			running_q     <= 1'b0;
			dir_q         <= 1'b0;
			enable_q      <= 1'b0;
			abort_q       <= 1'b0;
		end else if (adv) begin
			tick_count_q  <= tick_count_n;
			reload_q      <= reload_n;
			compare_q     <= compare_n;
			pulse_count_q <= pulse_count_n;
			pulse_goal_q  <= pulse_goal_n;
			running_q     <= running_n;
			dir_q         <= dir_n;
			enable_q      <= enable_n;
			abort_q       <= abort_n;
		end
	end

`ifndef SYNTHESIS
	// a running move always has the driver enabled
	assert property (@(posedge clk) disable iff (!arst_n) running_q |-> enable_q)
		else $error("running without enable");
	// counters are cleared whenever no move runs
	assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (pulse_count_q == '0 && pulse_goal_q == '0))
		else $error("stale pulse counters while idle");
	// reaching the goal ends the move
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.move_done) |=> !running_q)
		else $error("move still running after done");
	// move restarts the period counter
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item.cmd == CMD_MOVE) |=> (running_q && tick_count_q == '0))
		else $error("move did not start cleanly");
`endif

endmodule

`default_nettype wire

>>> sv/stepper_pulse_train_generator.sv
// Top level: input register, output register, config registers, handshakes.
// Depends on spg_pkg and spg_core.
//
// Channel  Direction  Handshake            Payload
// in       in         in_valid / in_stall  cmd, pulse_target, direction, period_reload
// out      out        out_valid / out_stall step_level .. pulses_done
// cfg      in         cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_stall is low; the command is held in the
// input register, then the one-pass state update is loaded into the result register.
// The path that sets the clock is the 17x17 duty multiply followed by the step compare.
// Reset clears control and move state; reload, compare and config take their defaults.
// A stalled output holds; the input register keeps accepting until it too is full.
`default_nettype none

module stepper_pulse_train_generator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [2:0]                     cmd,
	input  wire logic [31:0]                    pulse_target,
	input  wire logic                           direction,
	input  wire logic [15:0]                    period_reload,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                step_level,
	output logic                                direction_level,
	output logic                                enable_level,
	output logic                                busy_res,
	output logic                                move_done,
	output logic                                aborted,
	output logic                                status,
	output logic [31:0]                         pulses_done,
	input  wire logic                           cfg_we,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [16:0]                    cfg_wdata
);
	import spg_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_calc;
	result_t res_q;
	logic    out_valid_q;
	logic    adv;
	logic    in_take;

	// Handshake control
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_period    <= MIN_PERIOD_RST;
			cfg_q.max_period    <= MAX_PERIOD_RST;
			cfg_q.duty_fraction <= DUTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_PERIOD: cfg_q.min_period    <= cfg_wdata[15:0];
				CFG_MAX_PERIOD: cfg_q.max_period    <= cfg_wdata[15:0];
				CFG_DUTY:       cfg_q.duty_fraction <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd           <= cmd;
			item_s1.pulse_target  <= pulse_target;
			item_s1.direction     <= direction;
			item_s1.period_reload <= period_reload;
		end
	end

	spg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_calc)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_calc;
		end
	end

	assign out_valid       = out_valid_q;
	assign step_level      = res_q.step_level;
	assign direction_level = res_q.direction_level;
	assign enable_level    = res_q.enable_level;
	assign busy_res        = res_q.busy_res;
	assign move_done       = res_q.move_done;
	assign aborted         = res_q.aborted;
	assign status          = res_q.status;
	assign pulses_done     = res_q.pulses_done;

`ifndef SYNTHESIS
	// a transaction only leaves the input stage into a free result register
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");
	// a held result stays put while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(res_q)))
		else $error("stalled result changed");
	// stall toward the input only when the input stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("stall without a pending transaction");
`endif

endmodule

`default_nettype wire
